/* rtl/random_bits_to_uniform_float_unit_macros.svh */
// assertion macros for the random bits to uniform float unit
// expects clk and arst_n in the scope of the module that uses them
`ifndef RANDOM_BITS_TO_UNIFORM_FLOAT_UNIT_MACROS_SVH
`define RANDOM_BITS_TO_UNIFORM_FLOAT_UNIT_MACROS_SVH

`define RBUF_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> cons) \
		else $error("rbuf assertion failed");

`define RBUF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> cons) \
		else $error("rbuf assertion failed");

`endif

/* rtl/rbuf_pkg.sv */
// package for the random bits to uniform float unit
// mode codes, exponent limits and the per-stage control struct; no dependencies
`default_nettype none

package rbuf_pkg;

	typedef enum logic [2:0] {
		FUNC_SGL        = 3'd0,
		FUNC_SGL_SIGNED = 3'd1,
		FUNC_DBL        = 3'd2,
		FUNC_DBL_SIGNED = 3'd3,
		FUNC_FAST       = 3'd4
	} func_t;

	localparam logic [7:0]  SGL_EXP_TOP = 8'd126;
	localparam logic [7:0]  SGL_EXP_MIN = 8'd94;
	localparam logic [10:0] DBL_EXP_TOP = 11'd1022;
	localparam logic [10:0] DBL_EXP_MIN = 11'd959;

	localparam logic [5:0] SGL_SHIFT_CAP = 6'(SGL_EXP_TOP - SGL_EXP_MIN);
	localparam logic [5:0] DBL_SHIFT_CAP = 6'(DBL_EXP_TOP - DBL_EXP_MIN);

	typedef struct packed {
		logic sign;
		logic dbl;
		logic zero;
	} ctrl_t;

endpackage

`default_nettype wire

/* rtl/random_bits_to_uniform_float_unit.sv */
// random bits to uniform float unit: five-stage normalise and pack pipeline
// depends on rbuf_pkg and random_bits_to_uniform_float_unit_macros.svh
// throughput: one item per cycle, busy is always low, the receiver cannot stall
// stages: operand prep, per-byte leading-zero count, count merge, shift, pack
// reset: arst_n clears the stage valid bits only, no clearing pass
`default_nettype none

`include "random_bits_to_uniform_float_unit_macros.svh"

module random_bits_to_uniform_float_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  func,
	input  wire logic [63:0] random_word,
	output logic             done,
	output logic [63:0]      result_bits
);

	logic             valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	rbuf_pkg::ctrl_t  ctrl_s1, ctrl_s2, ctrl_s3, ctrl_s4;
	logic [63:0]      v_s1, v_s2, v_s3;
	logic [7:0]       byte_nz_s2;
	logic [2:0]       byte_lz_s2 [8];
	logic [5:0]       shift_s3;
	logic [63:0]      shifted_s4;
	logic [10:0]      exp_s4;
	logic [63:0]      result_s5;

	logic             take;
	rbuf_pkg::ctrl_t  ctrl_in;
	logic [63:0]      v_in;
	logic [7:0]       byte_nz;
	logic [2:0]       byte_lz [8];
	logic [6:0]       lz;
	logic [5:0]       cap;
	logic [5:0]       shift;
	logic [63:0]      packed_res;

	assign busy = 1'b0;
	assign take = start && !busy;

	// operand prep
	always_comb begin
		ctrl_in = '0;
		v_in    = '0;
		case (func)
			rbuf_pkg::FUNC_SGL: begin
				v_in = {random_word[31:0], 32'd0};
			end
			rbuf_pkg::FUNC_SGL_SIGNED: begin
				v_in         = {random_word[30:0], 33'd0};
				ctrl_in.sign = random_word[31];
			end
			rbuf_pkg::FUNC_DBL: begin
				v_in        = random_word;
				ctrl_in.dbl = 1'b1;
			end
			rbuf_pkg::FUNC_DBL_SIGNED: begin
				v_in         = {random_word[62:0], 1'b0};
				ctrl_in.sign = random_word[63];
				ctrl_in.dbl  = 1'b1;
			end
			rbuf_pkg::FUNC_FAST: begin
				v_in         = {random_word[31:9], 41'd0};
				ctrl_in.zero = (random_word[31:9] == 23'd0);
			end
			default: begin
				ctrl_in.zero = 1'b1;
			end
		endcase
	end

	// per-byte leading-zero count, byte 0 is the top byte
	always_comb begin
		for (int b = 0; b < 8; b++) begin
			byte_nz[b] = (v_s1[63 - 8*b -: 8] != 8'd0);
			byte_lz[b] = 3'd0;
			for (int i = 0; i < 8; i++) begin
				if (v_s1[63 - 8*b - 7 + i]) begin
					byte_lz[b] = 3'(7 - i);
				end
			end
		end
	end

	// merge counts and clamp to the mode's shift limit
	always_comb begin
		lz = 7'd64;
		for (int b = 7; b >= 0; b--) begin
			if (byte_nz_s2[b]) begin
				lz = {1'b0, 3'(b), byte_lz_s2[b]};
			end
		end
		cap   = ctrl_s2.dbl ? rbuf_pkg::DBL_SHIFT_CAP : rbuf_pkg::SGL_SHIFT_CAP;
		shift = (lz > {1'b0, cap}) ? cap : lz[5:0];
	end

	always_comb begin
		if (ctrl_s4.zero) begin
			packed_res = '0;
		end else if (ctrl_s4.dbl) begin
			packed_res = {ctrl_s4.sign, exp_s4, shifted_s4[62:11]};
		end else begin
			packed_res = {32'd0, ctrl_s4.sign, exp_s4[7:0], shifted_s4[62:40]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s1 <= take;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		ctrl_s1    <= ctrl_in;
		v_s1       <= v_in;
		ctrl_s2    <= ctrl_s1;
		v_s2       <= v_s1;
		byte_nz_s2 <= byte_nz;
		byte_lz_s2 <= byte_lz;
		ctrl_s3    <= ctrl_s2;
		v_s3       <= v_s2;
		shift_s3   <= shift;
		ctrl_s4    <= ctrl_s3;
		shifted_s4 <= v_s3 << shift_s3;
		exp_s4     <= ctrl_s3.dbl ? (rbuf_pkg::DBL_EXP_TOP - 11'(shift_s3))
			: (11'(rbuf_pkg::SGL_EXP_TOP) - 11'(shift_s3));
		result_s5  <= packed_res;
	end

	assign done        = valid_s5;
	assign result_bits = result_s5;

	`RBUF_ASSERT_IMP(a_latency, take, ##5 done)
	`RBUF_ASSERT_IMP(a_no_spurious_done, done, $past(take, 5))
	`RBUF_ASSERT_NEXT(a_valid_chain, valid_s3, valid_s4)
	`RBUF_ASSERT_IMP(a_sgl_exp_range, valid_s4 && !ctrl_s4.dbl,
		exp_s4 >= 11'(rbuf_pkg::SGL_EXP_MIN) && exp_s4 <= 11'(rbuf_pkg::SGL_EXP_TOP))
	`RBUF_ASSERT_IMP(a_dbl_exp_range, valid_s4 && ctrl_s4.dbl,
		exp_s4 >= rbuf_pkg::DBL_EXP_MIN && exp_s4 <= rbuf_pkg::DBL_EXP_TOP)

endmodule

`default_nettype wire

/* tb/sv/random_bits_to_uniform_float_checker.sv */
// checker for the random bits to uniform float unit: watches the start and done channels,
// predicts each ieee 754 pattern and compares it with the block's result
// depends on rbuf_pkg
module random_bits_to_uniform_float_checker
	import rbuf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [2:0]  func,
	input  logic [63:0] random_word,
	input  logic        done,
	input  logic [63:0] result_bits,
	output int          fail_count,
	output int          pending_count,
	output int          checked_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SGL_BIAS = 127;
	localparam int FAST_MANT_BITS = 23;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [2:0]  mode;
		logic [63:0] word;
		logic [63:0] bits;
	} deviate_t;

	deviate_t deviate_q[$];
	deviate_t oldest;
	int       fail_total = 0;
	int       checked_total = 0;

	initial begin
		fail_count = 0;
		pending_count = 0;
		checked_count = 0;
	end

	function automatic logic [63:0] pack_unit_single(input logic [31:0] bits);
		logic [31:0] w;
		logic [7:0]  e;
		w = bits;
		e = SGL_EXP_TOP;
		while (!w[31] && e > SGL_EXP_MIN) begin
			w = w << 1;
			e = e - 8'd1;
		end
		return {32'd0, 1'b0, e, w[30:8]};
	endfunction

	function automatic logic [63:0] pack_unit_double(input logic [63:0] bits);
		logic [63:0] w;
		logic [10:0] e;
		w = bits;
		e = DBL_EXP_TOP;
		while (!w[63] && e > DBL_EXP_MIN) begin
			w = w << 1;
			e = e - 11'd1;
		end
		return {1'b0, e, w[62:11]};
	endfunction

	function automatic logic [63:0] pack_fast_single(input logic [31:0] bits);
		logic [22:0] m;
		logic [22:0] frac;
		int          p;
		m = bits[31:9];
		if (m == '0)
			return '0;
		p = FAST_MANT_BITS - 1;
		while (!m[p])
			p--;
		frac = 23'(m << (FAST_MANT_BITS - p));
		return {32'd0, 1'b0, 8'(SGL_BIAS - FAST_MANT_BITS + p), frac};
	endfunction

	function automatic logic [63:0] predict_deviate(input logic [2:0] mode, input logic [63:0] w);
		case (mode)
			FUNC_SGL:        return pack_unit_single(w[31:0]);
			FUNC_SGL_SIGNED: return pack_unit_single({w[30:0], 1'b0}) | {32'd0, w[31], 31'd0};
			FUNC_DBL:        return pack_unit_double(w);
			FUNC_DBL_SIGNED: return pack_unit_double({w[62:0], 1'b0}) | {w[63], 63'd0};
			FUNC_FAST:       return pack_fast_single(w[31:0]);
			default:         return '0;
		endcase
	endfunction

	// result side first: a result at this edge belongs to an earlier transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (deviate_q.size() == 0) begin
					fail_total++;
					if (fail_total <= REPORT_LIMIT)
						$display("unexpected result %h with nothing pending", result_bits);
				end else begin
					oldest = deviate_q.pop_front();
					checked_total++;
					if (result_bits !== oldest.bits) begin
						fail_total++;
						if (fail_total <= REPORT_LIMIT)
							$display("mismatch func %0d word %h: expected %h got %h",
								oldest.mode, oldest.word, oldest.bits, result_bits);
					end
				end
			end
			if (start && !busy)
				deviate_q.push_back('{func, random_word, predict_deviate(func, random_word)});
			pending_count <= deviate_q.size();
			fail_count <= fail_total;
			checked_count <= checked_total;
		end
	end

endmodule

/* tb/sv/tb_random_bits_to_uniform_float_unit.sv */
// testbench top for the random bits to uniform float unit: clock, reset, directed and random
// transfers with random idling, watchdog and verdict
// depends on rbuf_pkg, random_bits_to_uniform_float_unit and random_bits_to_uniform_float_checker
module tb_random_bits_to_uniform_float_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import rbuf_pkg::*;

	localparam logic [2:0] FUNC_UNDEF_LO = 3'd5;
	localparam logic [2:0] FUNC_UNDEF_HI = 3'd7;
	localparam int RANDOM_ITEMS = 1525;
	localparam int PRESSURE_AT = 700;
	localparam int MAX_GAP = 17;
	localparam int DRAIN_CYCLES = 20;
	localparam int IDLE_LIMIT = 500;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  func;
	logic [63:0] random_word;
	logic        done;
	logic [63:0] result_bits;
	int          fail_count;
	int          pending_count;
	int          checked_count;
	int          idle_cycles = 0;
	int          mode_count[8];
	int          sent_total = 0;
	bit          no_idle = 1'b0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	random_bits_to_uniform_float_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.func        (func),
		.random_word (random_word),
		.done        (done),
		.result_bits (result_bits)
	);

	random_bits_to_uniform_float_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.func          (func),
		.random_word   (random_word),
		.done          (done),
		.result_bits   (result_bits),
		.fail_count    (fail_count),
		.pending_count (pending_count),
		.checked_count (checked_count)
	);

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (idle_cycles >= IDLE_LIMIT);
		$display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
		$display("TB_ERROR");
		$finish;
	end

	function automatic int draw_gap();
		return no_idle ? 0 : $urandom_range(0, MAX_GAP);
	endfunction

	task automatic send_item(input logic [2:0] f, input logic [63:0] w);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		func <= f;
		random_word <= w;
		do @(posedge clk); while (busy);
		mode_count[f]++;
		sent_total++;
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		do @(posedge clk); while (pending_count != 0);
	endtask

	// random content, often with leading zeros to exercise the shift range
	function automatic logic [63:0] draw_word();
		logic [63:0] w;
		w = {$urandom, $urandom};
		case ($urandom_range(0, 3))
			0: w = w >> $urandom_range(0, 64);
			1: w[31:0] = w[31:0] >> $urandom_range(0, 32);
			2: w[30:0] = w[30:0] >> $urandom_range(0, 31);
			default: ;
		endcase
		if ($urandom_range(0, 3) == 0)
			w[63] = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 3) == 0)
			w[31] = 1'($urandom_range(0, 1));
		return w;
	endfunction

	initial begin
		logic [2:0] f;
		arst_n = 1'b0;
		start = 1'b0;
		func = FUNC_SGL;
		random_word = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes of every mode, shift caps, sign and zero corners, undefined selectors
		for (int m = FUNC_SGL; m <= FUNC_FAST; m++) begin
			send_item(3'(m), '0);
			send_item(3'(m), '1);
		end
		send_item(FUNC_SGL, 64'h0000_0000_0000_0001);
		send_item(FUNC_SGL, 64'h0000_0000_8000_0000);
		send_item(FUNC_SGL, 64'hFFFF_FFFF_0000_0001);
		send_item(FUNC_SGL_SIGNED, 64'h0000_0000_8000_0000);
		send_item(FUNC_SGL_SIGNED, 64'h0000_0000_0000_0001);
		send_item(FUNC_DBL, 64'h0000_0000_0000_0001);
		send_item(FUNC_DBL, 64'h8000_0000_0000_0000);
		send_item(FUNC_DBL_SIGNED, 64'h8000_0000_0000_0000);
		send_item(FUNC_DBL_SIGNED, 64'h0000_0000_0000_0001);
		send_item(FUNC_FAST, 64'h0000_0000_0000_0200);
		send_item(FUNC_FAST, 64'h0000_0000_0000_01FF);
		send_item(FUNC_FAST, 64'h0000_0000_8000_0000);
		for (int m = FUNC_UNDEF_LO; m <= FUNC_UNDEF_HI; m++)
			send_item(3'(m), '1);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 64 == 0)
				no_idle = ($urandom_range(0, 3) == 0);
			if (i == PRESSURE_AT)
				wait_drained();
			if ($urandom_range(0, 19) == 0)
				f = 3'($urandom_range(FUNC_UNDEF_LO, FUNC_UNDEF_HI));
			else
				f = 3'($urandom_range(FUNC_SGL, FUNC_FAST));
			send_item(f, draw_word());
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d transfers sent, %0d results checked", sent_total, checked_count);
		$display("per mode 0..7: %0d %0d %0d %0d %0d %0d %0d %0d", mode_count[0], mode_count[1],
			mode_count[2], mode_count[3], mode_count[4], mode_count[5], mode_count[6],
			mode_count[7]);
		if (pending_count != 0)
			$display("%0d expected results never arrived", pending_count);
		if (fail_count == 0 && pending_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
